>>> hdl/cfd_pkg.sv
// Shared types, constants and CRC step functions for the frame deframer.
`default_nettype none

package cfd_pkg;

  // Phase of the receive state machine, one-hot
  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_HEAD  = 7'b0000100,
    PH_HCRC  = 7'b0001000,
    PH_PAY   = 7'b0010000,
    PH_CRCL  = 7'b0100000,
    PH_CRCH  = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HCRC = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_PCRC = 2'd3
  } status_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Register map: index is paddr[3:2]
  localparam int unsigned REG_ADDR_W = 4;
  localparam logic [1:0] REG_SOF_FIRST   = 2'd0;
  localparam logic [1:0] REG_SOF_SECOND  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SOF_FIRST_RST   = 8'h55;
  localparam logic [7:0]  SOF_SECOND_RST  = 8'hAA;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [7:0]  CRC8_INIT  = 8'h00;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [15:0] SKIP_MAX   = 16'hFFFF;

  // Header field positions counted from the first marker byte
  localparam logic [15:0] POS_TYPE    = 16'd2;
  localparam logic [15:0] POS_SEQ     = 16'd3;
  localparam logic [15:0] POS_ACK_LO  = 16'd4;
  localparam logic [15:0] POS_ACK_HI  = 16'd5;
  localparam logic [15:0] POS_LEN_LO  = 16'd6;
  localparam logic [15:0] POS_HDR_END = 16'd8;

  typedef struct packed {
    logic [7:0]  sof_first;
    logic [7:0]  sof_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  sequence_res;
    logic [15:0] ack_number;
    logic [15:0] payload_length;
    logic [15:0] skipped_bytes;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC16_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cfd_if.sv
// Handshake channels: received byte stream and deframer results.
`default_nettype none

interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_res_if
  import cfd_pkg::*;
;
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/cfd_apb_regs.sv
// APB configuration registers: marker bytes and payload length limit.
`default_nettype none

module cfd_apb_regs
  import cfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  output      cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_first   <= SOF_FIRST_RST;
      cfg_q.sof_second  <= SOF_SECOND_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SOF_FIRST:   cfg_q.sof_first   <= pwdata[7:0];
        REG_SOF_SECOND:  cfg_q.sof_second  <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SOF_FIRST:   prdata = {24'd0, cfg_q.sof_first};
      REG_SOF_SECOND:  prdata = {24'd0, cfg_q.sof_second};
      REG_MAX_PAYLOAD: prdata = {16'd0, cfg_q.max_payload};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/cfd_core.sv
// Byte input register and single-pass deframing state machine with CRC checks.
`default_nettype none

module cfd_core
  import cfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  output      logic       in_ready_o,
  input  wire cfg_t       cfg_i,
  input  wire logic       space_i,
  output      logic       res_valid_o,
  output      res_t       res_o
);

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        adv;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  hcrc_q, hcrc_d;
  logic [15:0] bcrc_q, bcrc_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] ack_q, ack_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] skip_q, skip_d;

  logic [15:0] pos_inc;
  logic [15:0] skip_sat;
  logic [15:0] skip_sat2;
  logic [7:0]  hcrc_upd;
  logic [15:0] bcrc_upd;
  logic        res_vld;
  res_t        res;

  // Work on the held word once the result buffer has room
  assign adv        = in_vld_q && space_i;
  assign in_ready_o = !in_vld_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign pos_inc   = pos_q + 16'd1;
  assign skip_sat  = (skip_q == SKIP_MAX) ? skip_q : skip_q + 16'd1;
  assign skip_sat2 = (skip_sat == SKIP_MAX) ? skip_sat : skip_sat + 16'd1;
  assign hcrc_upd  = crc8_step(hcrc_q, byte_q);
  assign bcrc_upd  = crc16_step(bcrc_q, byte_q);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hcrc_d   = hcrc_q;
    bcrc_d   = bcrc_q;
    type_d   = type_q;
    seq_d    = seq_q;
    ack_d    = ack_q;
    len_d    = len_q;
    crc_lo_d = crc_lo_q;
    skip_d   = skip_q;
    res_vld  = 1'b0;

    res.kind           = KIND_STATUS;
    res.payload_byte   = 8'd0;
    res.status         = ST_OK;
    res.frame_type     = type_q;
    res.sequence_res   = seq_q;
    res.ack_number     = ack_q;
    res.payload_length = len_q;
    res.skipped_bytes  = skip_q;

    unique case (phase_q)
      PH_HUNT2: begin
        if (byte_q == cfg_i.sof_second) begin
          hcrc_d  = hcrc_upd;
          bcrc_d  = CRC16_INIT;
          pos_d   = POS_TYPE;
          phase_d = PH_HEAD;
        end else if (byte_q == cfg_i.sof_first) begin
          // Broken marker: count the stale first byte, restart on this one
          skip_d  = skip_sat;
          hcrc_d  = crc8_step(CRC8_INIT, byte_q);
          phase_d = PH_HUNT2;
        end else begin
          skip_d  = skip_sat2;
          phase_d = PH_HUNT1;
        end
      end
      PH_HEAD: begin
        hcrc_d = hcrc_upd;
        bcrc_d = bcrc_upd;
        unique case (pos_q)
          POS_TYPE:   type_d = byte_q;
          POS_SEQ:    seq_d  = byte_q;
          POS_ACK_LO: ack_d  = {ack_q[15:8], byte_q};
          POS_ACK_HI: ack_d  = {byte_q, ack_q[7:0]};
          POS_LEN_LO: len_d  = {len_q[15:8], byte_q};
          default:    len_d  = {byte_q, len_q[7:0]};
        endcase
        pos_d = pos_inc;
        if (pos_inc >= POS_HDR_END || pos_inc < POS_TYPE) begin
          phase_d = PH_HCRC;
        end
      end
      PH_HCRC: begin
        bcrc_d = bcrc_upd;
        if (byte_q != hcrc_q || len_q > cfg_i.max_payload) begin
          res_vld    = 1'b1;
          res.status = (byte_q != hcrc_q) ? ST_BAD_HCRC : ST_BAD_LEN;
          skip_d     = 16'd0;
          pos_d      = 16'd0;
          phase_d    = PH_HUNT1;
        end else begin
          pos_d   = 16'd0;
          phase_d = (len_q == 16'd0) ? PH_CRCL : PH_PAY;
        end
      end
      PH_PAY: begin
        bcrc_d = bcrc_upd;
        pos_d  = pos_inc;
        if (pos_inc >= len_q) begin
          phase_d = PH_CRCL;
        end
        res_vld           = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = byte_q;
        res.skipped_bytes = 16'd0;
      end
      PH_CRCL: begin
        crc_lo_d = byte_q;
        phase_d  = PH_CRCH;
      end
      PH_CRCH: begin
        res_vld    = 1'b1;
        res.status = ({byte_q, crc_lo_q} == bcrc_q) ? ST_OK : ST_BAD_PCRC;
        skip_d     = 16'd0;
        pos_d      = 16'd0;
        phase_d    = PH_HUNT1;
      end
      default: begin
        // Hunting for the first marker
        if (byte_q == cfg_i.sof_first) begin
          hcrc_d  = crc8_step(CRC8_INIT, byte_q);
          phase_d = PH_HUNT2;
        end else begin
          skip_d  = skip_sat;
          phase_d = PH_HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      pos_q    <= 16'd0;
      hcrc_q   <= CRC8_INIT;
      bcrc_q   <= CRC16_INIT;
      type_q   <= 8'd0;
      seq_q    <= 8'd0;
      ack_q    <= 16'd0;
      len_q    <= 16'd0;
      crc_lo_q <= 8'd0;
      skip_q   <= 16'd0;
    end else if (adv) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hcrc_q   <= hcrc_d;
      bcrc_q   <= bcrc_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
      ack_q    <= ack_d;
      len_q    <= len_d;
      crc_lo_q <= crc_lo_d;
      skip_q   <= skip_d;
    end
  end

  assign res_valid_o = adv && res_vld;
  assign res_o       = res;

`ifndef SYNTHESIS
  a_payload_only_in_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_PAYLOAD) |-> (phase_q == PH_PAY))
    else $error("payload word emitted outside payload phase");

  a_status_restarts_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_STATUS) |=> (phase_q == PH_HUNT1 && skip_q == 16'd0))
    else $error("status word not followed by a fresh hunt");

  a_head_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEAD) |-> (pos_q >= POS_TYPE && pos_q < POS_HDR_END))
    else $error("header position out of range");

  a_pay_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (pos_q < len_q))
    else $error("payload position beyond frame length");
`endif

endmodule

`default_nettype wire

>>> hdl/cfd_out_buf.sv
// Two-entry result buffer between the deframing logic and the result channel.
`default_nettype none

module cfd_out_buf
  import cfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output      logic space_o,
  output      logic valid_o,
  input  wire logic ready_i,
  output      res_t data_o
);

  res_t       entry_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/crc_checked_frame_deframer_top.sv
// A byte accepted into the input register is processed there by the deframing logic,
//   and any result word it yields is written into the result buffer for the channel.
// Throughput: one byte per cycle unless the result buffer is full, set by the single
//   input register and byte-wide CRC-8/CRC-16 update; its two entries absorb stalls.
// Reset: rst_ni is asynchronous, active low; it empties both stages, returns the
//   deframer to hunting for the first marker and loads the register defaults.
// Top level of the marker-framed, CRC-checked byte stream deframer.
`default_nettype none

module crc_checked_frame_deframer_top
  import cfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  cfd_rx_if.sink                     rx_i,
  cfd_res_if.source                  res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  cfg_t cfg;
  logic space;
  logic res_valid;
  res_t res;
  logic in_ready;
  logic out_valid;
  res_t out_data;

  cfd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (in_ready),
    .cfg_i       (cfg),
    .space_i     (space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfd_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_valid),
    .ready_i (res_o.ready),
    .data_o  (out_data)
  );

  assign rx_i.ready    = in_ready;
  assign res_o.valid   = out_valid;
  assign res_o.payload = out_data;

endmodule

`default_nettype wire
